/* src/tcw_pkg.sv */
package tcw_pkg;

	// default screen geometry
	localparam int DEF_SCREEN_COLUMNS = 80;
	localparam int DEF_SCREEN_ROWS    = 25;

	// item field widths
	localparam int OP_W    = 2;
	localparam int CODE_W  = 8;
	localparam int ADDR_W  = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;

	// character codes and reset values
	localparam logic [CODE_W-1:0]  NEWLINE_CODE      = 8'h0A;
	localparam logic [CODE_W-1:0]  BLANK_CODE        = 8'h20;
	localparam logic [CELL_W-1:0]  BLANK_CELL_RESET  = 16'h0720;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET  = 4'h7;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RESET  = 4'h0;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUT       = 2'd0,
		OP_BACKSPACE = 2'd1,
		OP_READ      = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic {
		CFG_TEXT_COLOR = 1'b0,
		CFG_BACK_COLOR = 1'b1
	} cfg_reg_t;

endpackage

/* src/text_console_writer_core.sv */
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------
// item in   | start && !busy            | operation, char_code, read_address
// result    | done (one-cycle strobe)   | cursor_position, cell_data
// config    | cfg_valid && cfg_ready    | cfg_index, cfg_data
//
// put without a scroll, plain backspace, read and the unused code keep busy low
// and the result strobes in the next cycle.
// backspace at column zero holds busy high in ST_BS_FIX for the fill record memory read.
// a put that scrolls runs ST_SCROLL then ST_FINISH with busy high: the screen
// memory moves one cell per cycle through its single write port.
// after reset a clearing pass blanks every cell of the screen with busy high;
// configuration writes are taken at all times.
// results cannot be stalled: done is high for exactly one cycle per item.
module text_console_writer_core #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tcw_pkg::OP_W-1:0]     operation,
	input  logic [tcw_pkg::CODE_W-1:0]   char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]   read_address,
	output logic                         done,
	output logic [tcw_pkg::POS_W-1:0]    cursor_position,
	output logic [tcw_pkg::CELL_W-1:0]   cell_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data
);

	import tcw_pkg::*;

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int RW    = $clog2(SCREEN_ROWS);
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BS_FIX,
		ST_SCROLL,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [AW-1:0]      idx_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic               done_q;
	logic               read_hit_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	// scroll pipeline stage
	logic               scr_pend_s1;
	logic [AW-1:0]      scr_waddr_s1;
	logic               copy_s1;
	logic               fill_pend_s1;
	logic [RW-1:0]      fill_waddr_s1;

	// memory ports
	logic              scr_we;
	logic [AW-1:0]     scr_waddr;
	logic [CELL_W-1:0] scr_wdata;
	logic              scr_re;
	logic [AW-1:0]     scr_raddr;
	logic [CELL_W-1:0] scr_rdata;
	logic              fill_we;
	logic [RW-1:0]     fill_waddr;
	logic [CW-1:0]     fill_wdata;
	logic              fill_re;
	logic [RW-1:0]     fill_raddr;
	logic [CW-1:0]     fill_rdata;

	// decoded item and cursor terms
	logic              accept;
	op_t               op;
	logic              is_newline;
	logic              col_last;
	logic              row_last;
	logic              row_end;
	logic              in_range;
	logic              copy_now;
	logic              fill_shift_now;
	logic [RW-1:0]     row_dec;
	logic [AW-1:0]     cur_idx;
	logic [CELL_W-1:0] blank_cell;

	assign accept         = start && (state_q == ST_IDLE);
	assign op             = op_t'(operation);
	assign is_newline     = (char_code == NEWLINE_CODE);
	assign col_last       = (32'(col_q) == SCREEN_COLUMNS - 1);
	assign row_last       = (32'(row_q) == SCREEN_ROWS - 1);
	assign row_end        = is_newline || col_last;
	assign in_range       = (32'(read_address) < CELLS);
	assign copy_now       = (32'(idx_q) < CELLS - SCREEN_COLUMNS);
	assign fill_shift_now = (32'(idx_q) < SCREEN_ROWS - 1);
	assign row_dec        = (row_q == '0) ? '0 : RW'(row_q - 1'b1);
	assign cur_idx        = AW'(32'(row_q) * SCREEN_COLUMNS + 32'(col_q));
	assign blank_cell     = {bg_q, fg_q, BLANK_CODE};

	// memory port selection
	always_comb begin
		scr_we     = 1'b0;
		scr_waddr  = cur_idx;
		scr_wdata  = blank_cell;
		scr_re     = 1'b0;
		scr_raddr  = AW'(read_address);
		fill_we    = 1'b0;
		fill_waddr = row_q;
		fill_wdata = col_q;
		fill_re    = 1'b0;
		fill_raddr = row_dec;
		unique case (state_q)
			ST_CLEAR: begin
				scr_we    = 1'b1;
				scr_waddr = idx_q;
				scr_wdata = BLANK_CELL_RESET;
				if (32'(idx_q) < SCREEN_ROWS) begin
					fill_we    = 1'b1;
					fill_waddr = RW'(idx_q);
					fill_wdata = '0;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_PUT: begin
							scr_we    = !is_newline;
							scr_wdata = {bg_q, fg_q, char_code};
							// a newline records the column, a wrap records the last one
							fill_we   = row_end;
						end
						OP_BACKSPACE: begin
							if (col_q == '0) begin
								fill_re = 1'b1;
							end else begin
								scr_we    = 1'b1;
								scr_waddr = AW'(cur_idx - 1'b1);
							end
						end
						OP_READ: begin
							scr_re = in_range;
						end
						OP_NONE: begin
						end
					endcase
				end
			end
			ST_BS_FIX: begin
				scr_we    = 1'b1;
				scr_waddr = AW'(32'(row_q) * SCREEN_COLUMNS + 32'(fill_rdata));
			end
			ST_SCROLL: begin
				// reads run one row ahead of writes, so they never meet
				scr_re     = copy_now;
				scr_raddr  = AW'(32'(idx_q) + SCREEN_COLUMNS);
				fill_re    = fill_shift_now;
				fill_raddr = RW'(32'(idx_q) + 1);
			end
			ST_FINISH: begin
			end
		endcase
		// scroll write-back stage
		if (scr_pend_s1) begin
			scr_we    = 1'b1;
			scr_waddr = scr_waddr_s1;
			scr_wdata = copy_s1 ? scr_rdata : blank_cell;
		end
		if (fill_pend_s1) begin
			fill_we    = 1'b1;
			fill_waddr = fill_waddr_s1;
			fill_wdata = fill_rdata;
		end
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			done_q       <= 1'b0;
			read_hit_q   <= 1'b0;
			scr_pend_s1  <= 1'b0;
			fill_pend_s1 <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			scr_pend_s1  <= 1'b0;
			fill_pend_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(idx_q) == CELLS - 1) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= AW'(idx_q + 1'b1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						read_hit_q <= (op == OP_READ) && in_range;
						done_q     <= 1'b1;
						unique case (op)
							OP_PUT: begin
								if (row_end) begin
									col_q <= '0;
									if (row_last) begin
										idx_q   <= '0;
										done_q  <= 1'b0;
										state_q <= ST_SCROLL;
									end else begin
										row_q <= RW'(row_q + 1'b1);
									end
								end else begin
									col_q <= CW'(col_q + 1'b1);
								end
							end
							OP_BACKSPACE: begin
								if (col_q == '0) begin
									row_q   <= row_dec;
									done_q  <= 1'b0;
									state_q <= ST_BS_FIX;
								end else begin
									col_q <= CW'(col_q - 1'b1);
								end
							end
							OP_READ: begin
							end
							OP_NONE: begin
							end
						endcase
					end
				end
				ST_BS_FIX: begin
					col_q   <= fill_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					scr_pend_s1  <= 1'b1;
					fill_pend_s1 <= fill_shift_now;
					if (32'(idx_q) == CELLS - 1) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= AW'(idx_q + 1'b1);
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scroll stage payload
	always_ff @(posedge clk) begin
		scr_waddr_s1  <= idx_q;
		copy_s1       <= copy_now;
		fill_waddr_s1 <= RW'(idx_q);
	end

	// color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= TEXT_COLOR_RESET;
			bg_q <= BACK_COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TEXT_COLOR: fg_q <= cfg_data;
				CFG_BACK_COLOR: bg_q <= cfg_data;
			endcase
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen_ram (
		.clk  (clk),
		.we   (scr_we),
		.waddr(scr_waddr),
		.wdata(scr_wdata),
		.re   (scr_re),
		.raddr(scr_raddr),
		.rdata(scr_rdata)
	);

	tcw_ram #(
		.WIDTH(CW),
		.DEPTH(SCREEN_ROWS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.re   (fill_re),
		.raddr(fill_raddr),
		.rdata(fill_rdata)
	);

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign cfg_ready       = 1'b1;
	assign cursor_position = POS_W'(32'(row_q) * SCREEN_COLUMNS + 32'(col_q));
	assign cell_data       = read_hit_q ? scr_rdata : '0;

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLUMNS))
		else $error("cursor off screen");

	// screen writes stay inside the cell store
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		scr_we |-> (32'(scr_waddr) < CELLS))
		else $error("screen write out of range");

	// a read item answers in the next cycle
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_READ)) |=> done)
		else $error("read item result missing");

	// scroll write-back only while scrolling or finishing the scroll
	a_s1_scope: assert property (@(posedge clk) disable iff (!arst_n)
		(scr_pend_s1 || fill_pend_s1) |-> ((state_q == ST_SCROLL) || (state_q == ST_FINISH)))
		else $error("stray scroll write");

endmodule

/* src/tcw_ram.sv */
module tcw_ram #(
	parameter int WIDTH = tcw_pkg::CELL_W,
	parameter int DEPTH = tcw_pkg::DEF_SCREEN_COLUMNS * tcw_pkg::DEF_SCREEN_ROWS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
